@@ rtl/polynomial_add_sub_multiply_core_defines.svh @@
// Assertion macros shared by the polynomial add, subtract and multiply core
`ifndef POLYNOMIAL_ADD_SUB_MULTIPLY_CORE_DEFINES_SVH
`define POLYNOMIAL_ADD_SUB_MULTIPLY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PASM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pasm assertion failed");
`define PASM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pasm assertion failed");
`else
`define PASM_ASSERT(label, prop)
`define PASM_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ rtl/pasm_pkg.sv @@
// Package: widths, action codes and microcode table of the polynomial core
`timescale 1ns / 1ps

package pasm_pkg;

    localparam int MAX_DEGREE = 10;
    localparam int N_COEF     = MAX_DEGREE + 1;

    localparam int ACT_W   = 3;
    localparam int IDX_W   = 4;
    localparam int COEF_W  = 16;
    localparam int OPOW_W  = 5;
    localparam int ACC_W   = 36;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int UPC_W   = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    localparam logic [ACT_W-1:0] ACT_LOAD_A = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUB    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MUL    = 3'd4;

    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc PC_FETCH    = 3'd0;
    localparam t_upc PC_ADDSUB   = 3'd1;
    localparam t_upc PC_MUL_INIT = 3'd2;
    localparam t_upc PC_MUL_MAC  = 3'd3;
    localparam t_upc PC_MUL_DRN  = 3'd4;
    localparam t_upc PC_MUL_OUT  = 3'd5;

    typedef enum logic [1:0] {
        J_NEXT     = 2'd0,
        J_DISPATCH = 2'd1,
        J_ILOOP    = 2'd2,
        J_KLOOP    = 2'd3
    } t_jcond;

    typedef struct packed {
        logic   ready;
        logic   acc_init;
        logic   mac;
        logic   drain;
        logic   out_wr;
        logic   out_mul;
        t_jcond jcond;
        t_upc   target;
    } t_uword;

    function automatic t_uword urom(input t_upc pc);
        t_uword w;
        w = '0;
        w.jcond  = J_NEXT;
        w.target = PC_FETCH;
        unique case (pc)
            PC_FETCH: begin
                w.ready  = 1'b1;
                w.jcond  = J_DISPATCH;
                w.target = PC_ADDSUB;
            end
            PC_ADDSUB: begin
                w.out_wr = 1'b1;
                w.jcond  = J_KLOOP;
                w.target = PC_ADDSUB;
            end
            PC_MUL_INIT: begin
                w.acc_init = 1'b1;
            end
            PC_MUL_MAC: begin
                w.mac    = 1'b1;
                w.jcond  = J_ILOOP;
                w.target = PC_MUL_DRN;
            end
            PC_MUL_DRN: begin
                w.drain = 1'b1;
            end
            PC_MUL_OUT: begin
                w.out_wr  = 1'b1;
                w.out_mul = 1'b1;
                w.jcond   = J_KLOOP;
                w.target  = PC_MUL_INIT;
            end
            default: begin
                w.jcond  = J_KLOOP;
                w.target = PC_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/polynomial_add_sub_multiply_core.sv @@
// Top level: microcoded polynomial add, subtract and multiply core
// Load beats are accepted in the fetch state and give no result.
// Add and subtract: accepted in fetch, then one result beat a cycle while the sink takes them, max(d1,d2)+1 beats.
// Multiply: per result coefficient k, an init step, n(k) multiply-accumulate steps, a drain step and an output step;
// up to 121 products at degree 10, all through the one shared MAC step.
// Results sit in an output register; a stalled sink holds the sequencer.
// Synchronous active-low reset clears both polynomials, both degrees and the sequencer.
`timescale 1ns / 1ps

`include "polynomial_add_sub_multiply_core_defines.svh"

module polynomial_add_sub_multiply_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // power [3:0], value [19:4], zero fill [23:20]
    input  logic [pasm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // action [2:0]
    input  logic [pasm_pkg::ACT_W-1:0]       s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_power [4:0], out_value [40:5], zero fill [47:41]
    output logic [pasm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tlast
);

    logic signed [pasm_pkg::COEF_W-1:0] r_fa [pasm_pkg::N_COEF];
    logic signed [pasm_pkg::COEF_W-1:0] r_sb [pasm_pkg::N_COEF];
    logic [pasm_pkg::IDX_W-1:0]         r_d1;
    logic [pasm_pkg::IDX_W-1:0]         r_d2;

    pasm_pkg::t_upc                     r_pc;
    pasm_pkg::t_upc                     n_pc;
    pasm_pkg::t_uword                   w_ctl;

    logic                               r_mul;
    logic                               r_sub;
    logic [pasm_pkg::OPOW_W-1:0]        r_k;
    logic [pasm_pkg::IDX_W-1:0]         r_i;
    logic signed [pasm_pkg::PROD_W-1:0] r_prod;
    logic                               r_pv;
    logic signed [pasm_pkg::ACC_W-1:0]  r_acc;

    logic                               r_ovld;
    logic [pasm_pkg::OPOW_W-1:0]        r_opow;
    logic signed [pasm_pkg::ACC_W-1:0]  r_oval;
    logic                               r_olast;

    logic [pasm_pkg::ACT_W-1:0]         w_act;
    logic [pasm_pkg::IDX_W-1:0]         w_pow;
    logic signed [pasm_pkg::COEF_W-1:0] w_val;
    logic                               w_in_acc;
    logic                               w_cmp_acc;
    logic                               w_ld_ok;

    logic [pasm_pkg::OPOW_W-1:0]        w_d1x;
    logic [pasm_pkg::OPOW_W-1:0]        w_d2x;
    logic [pasm_pkg::OPOW_W-1:0]        w_top;
    logic [pasm_pkg::OPOW_W-1:0]        w_lo;
    logic [pasm_pkg::IDX_W-1:0]         w_hi;
    logic [pasm_pkg::OPOW_W-1:0]        w_j;
    logic signed [pasm_pkg::COEF_W-1:0] w_a;
    logic signed [pasm_pkg::COEF_W-1:0] w_b;
    logic signed [pasm_pkg::ACC_W-1:0]  w_addsub;
    logic signed [pasm_pkg::ACC_W-1:0]  w_pext;
    logic                               w_out_free;
    logic                               w_adv;

    assign w_act = s_axis_tuser;
    assign w_pow = s_axis_tdata[3:0];
    assign w_val = s_axis_tdata[19:4];

    assign w_ctl         = pasm_pkg::urom(r_pc);
    assign s_axis_tready = w_ctl.ready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cmp_acc     = w_in_acc && ((w_act == pasm_pkg::ACT_ADD) ||
                           (w_act == pasm_pkg::ACT_SUB) || (w_act == pasm_pkg::ACT_MUL));
    assign w_ld_ok       = {1'b0, w_pow} <= pasm_pkg::OPOW_W'(pasm_pkg::MAX_DEGREE);

    assign w_d1x = {1'b0, r_d1};
    assign w_d2x = {1'b0, r_d2};
    assign w_top = r_mul ? (w_d1x + w_d2x) : ((r_d1 > r_d2) ? w_d1x : w_d2x);
    assign w_lo  = (r_k > w_d2x) ? (r_k - w_d2x) : '0;
    assign w_hi  = (r_k < w_d1x) ? r_k[pasm_pkg::IDX_W-1:0] : r_d1;
    assign w_j   = r_k - {1'b0, r_i};

    always_comb begin
        w_a = '0;
        w_b = '0;
        if (r_k <= w_d1x) begin
            w_a = r_fa[r_k[pasm_pkg::IDX_W-1:0]];
        end
        if (r_k <= w_d2x) begin
            w_b = r_sb[r_k[pasm_pkg::IDX_W-1:0]];
        end
    end

    assign w_addsub = r_sub ?
        (pasm_pkg::ACC_W'(w_a) - pasm_pkg::ACC_W'(w_b)) :
        (pasm_pkg::ACC_W'(w_a) + pasm_pkg::ACC_W'(w_b));
    assign w_pext   = pasm_pkg::ACC_W'(r_prod);

    assign w_out_free = !r_ovld || m_axis_tready;
    assign w_adv      = !(w_ctl.out_wr && !w_out_free);

    always_comb begin
        n_pc = r_pc;
        unique case (w_ctl.jcond)
            pasm_pkg::J_NEXT: begin
                n_pc = pasm_pkg::t_upc'(r_pc + 1'b1);
            end
            pasm_pkg::J_DISPATCH: begin
                if (w_cmp_acc) begin
                    n_pc = (w_act == pasm_pkg::ACT_MUL) ? pasm_pkg::PC_MUL_INIT : w_ctl.target;
                end
            end
            pasm_pkg::J_ILOOP: begin
                if (r_i == w_hi) begin
                    n_pc = w_ctl.target;
                end
            end
            pasm_pkg::J_KLOOP: begin
                if (w_adv) begin
                    n_pc = (r_k == w_top) ? pasm_pkg::PC_FETCH : w_ctl.target;
                end
            end
            default: begin
                n_pc = pasm_pkg::PC_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pasm_pkg::PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
            for (int q = 0; q < pasm_pkg::N_COEF; q++) begin
                r_fa[q] <= '0;
                r_sb[q] <= '0;
            end
        end else if (w_in_acc && w_ld_ok) begin
            if (w_act == pasm_pkg::ACT_LOAD_A) begin
                for (int q = 0; q < pasm_pkg::N_COEF; q++) begin
                    if (pasm_pkg::IDX_W'(q) == w_pow) begin
                        r_fa[q] <= w_val;
                    end else if (s_axis_tlast && (pasm_pkg::IDX_W'(q) > w_pow)) begin
                        r_fa[q] <= '0;
                    end
                end
                if (s_axis_tlast) begin
                    r_d1 <= w_pow;
                end
            end else if (w_act == pasm_pkg::ACT_LOAD_B) begin
                for (int q = 0; q < pasm_pkg::N_COEF; q++) begin
                    if (pasm_pkg::IDX_W'(q) == w_pow) begin
                        r_sb[q] <= w_val;
                    end else if (s_axis_tlast && (pasm_pkg::IDX_W'(q) > w_pow)) begin
                        r_sb[q] <= '0;
                    end
                end
                if (s_axis_tlast) begin
                    r_d2 <= w_pow;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmp_acc) begin
            r_k   <= '0;
            r_mul <= (w_act == pasm_pkg::ACT_MUL);
            r_sub <= (w_act == pasm_pkg::ACT_SUB);
        end else if (w_ctl.out_wr && w_adv) begin
            r_k <= r_k + 1'b1;
        end
        if (w_ctl.acc_init) begin
            r_i   <= w_lo[pasm_pkg::IDX_W-1:0];
            r_acc <= '0;
        end
        if (w_ctl.mac) begin
            r_i    <= r_i + 1'b1;
            r_prod <= r_fa[r_i] * r_sb[w_j[pasm_pkg::IDX_W-1:0]];
            if (r_pv) begin
                r_acc <= r_acc + w_pext;
            end
        end
        if (w_ctl.drain) begin
            r_acc <= r_acc + w_pext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_ctl.acc_init) begin
            r_pv <= 1'b0;
        end else if (w_ctl.mac) begin
            r_pv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_ctl.out_wr && w_out_free) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_wr && w_out_free) begin
            r_opow  <= r_k;
            r_oval  <= w_ctl.out_mul ? r_acc : w_addsub;
            r_olast <= (r_k == w_top);
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {7'd0, r_oval, r_opow};
    assign m_axis_tlast  = r_olast;

    `PASM_ASSERT(a_mac_in_bounds, (r_pc == pasm_pkg::PC_MUL_MAC) |-> (r_i <= w_hi))
    `PASM_ASSERT(a_k_in_bounds, (r_pc != pasm_pkg::PC_FETCH) |-> (r_k <= w_top))
    `PASM_ASSERT(a_compute_leaves_fetch, w_cmp_acc |=> (r_pc != pasm_pkg::PC_FETCH))
    `PASM_ASSERT_ALWAYS(a_ready_only_in_fetch, s_axis_tready |-> (r_pc == pasm_pkg::PC_FETCH))

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for the polynomial core: directed and random beats against a coefficient predictor
`timescale 1ns / 1ps

module testbench;
    import pasm_pkg::*;

    localparam int ITEM_TARGET    = 310;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int TAIL_CYCLES    = 200;
    localparam int IDLE_START_PCT = 5;
    localparam int DRAIN_EVERY    = 70;

    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OPOW_W-1:0] pwr;
        logic [ACC_W-1:0]  val;
        logic              lst;
    } t_coef_beat;

    class poly_coef_tracker;
        logic signed [COEF_W-1:0] first_c [N_COEF];
        logic signed [COEF_W-1:0] second_c [N_COEF];
        logic [IDX_W-1:0]         first_deg;
        logic [IDX_W-1:0]         second_deg;
        t_coef_beat               pending_coefs [$];
        int                       mismatches;

        function new();
            foreach (first_c[k]) begin
                first_c[k]  = '0;
                second_c[k] = '0;
            end
            first_deg  = '0;
            second_deg = '0;
            mismatches = 0;
        endfunction

        function logic signed [ACC_W-1:0] coef_of(bit from_second, int k);
            logic signed [ACC_W-1:0] r;
            r = '0;
            if (from_second) begin
                if (k <= second_deg && k < N_COEF) r = second_c[k];
            end else begin
                if (k <= first_deg && k < N_COEF) r = first_c[k];
            end
            return r;
        endfunction

        function void store_coef(bit to_second, int pwr, logic signed [COEF_W-1:0] val,
                                 logic lst);
            if (pwr > MAX_DEGREE) return;
            if (to_second) begin
                second_c[pwr] = val;
                if (lst) begin
                    second_deg = IDX_W'(pwr);
                    for (int k = pwr + 1; k < N_COEF; k++) second_c[k] = '0;
                end
            end else begin
                first_c[pwr] = val;
                if (lst) begin
                    first_deg = IDX_W'(pwr);
                    for (int k = pwr + 1; k < N_COEF; k++) first_c[k] = '0;
                end
            end
        endfunction

        function void push_coef(int k, int top, logic signed [ACC_W-1:0] acc);
            t_coef_beat beat;
            beat.pwr = OPOW_W'(k);
            beat.val = acc;
            beat.lst = (k == top);
            pending_coefs.push_back(beat);
        endfunction

        function void take_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] pwr,
                                logic [COEF_W-1:0] val, logic lst);
            int                      top;
            logic signed [ACC_W-1:0] a;
            logic signed [ACC_W-1:0] b;
            logic signed [ACC_W-1:0] acc;
            case (act)
                ACT_LOAD_A: store_coef(1'b0, int'(pwr), val, lst);
                ACT_LOAD_B: store_coef(1'b1, int'(pwr), val, lst);
                ACT_ADD, ACT_SUB: begin
                    top = (first_deg > second_deg) ? first_deg : second_deg;
                    for (int k = 0; k <= top; k++) begin
                        a = coef_of(1'b0, k);
                        b = coef_of(1'b1, k);
                        acc = (act == ACT_ADD) ? a + b : a - b;
                        push_coef(k, top, acc);
                    end
                end
                ACT_MUL: begin
                    top = int'(first_deg) + int'(second_deg);
                    for (int k = 0; k <= top; k++) begin
                        acc = '0;
                        for (int i = 0; i <= k; i++)
                            acc += coef_of(1'b0, i) * coef_of(1'b1, k - i);
                        push_coef(k, top, acc);
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what, longint want, longint got);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void match_coef(t_coef_beat got);
            t_coef_beat want;
            if (pending_coefs.size() == 0) begin
                mismatches++;
                $display("%0t: extra beat, expected none, actual power %0d value %0d last %0b",
                         $time, got.pwr, $signed(got.val), got.lst);
                return;
            end
            want = pending_coefs.pop_front();
            if (got.pwr !== want.pwr) report("power", want.pwr, got.pwr);
            if (got.val !== want.val) report("value", $signed(want.val), $signed(got.val));
            if (got.lst !== want.lst) report("last", want.lst, got.lst);
        endfunction

        function int outstanding();
            return pending_coefs.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [ACT_W-1:0]     s_axis_tuser  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    poly_coef_tracker sb;
    bit               gaps_on     = 1'b1;
    bit               stalls_on   = 1'b1;
    int               items_taken = 0;
    int               sink_hold   = 0;
    int               cycle_count = 0;
    logic [ACT_W-1:0] calc_ops [3] = '{ACT_ADD, ACT_SUB, ACT_MUL};

    polynomial_add_sub_multiply_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_coef_beat got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pwr = m_axis_tdata[OPOW_W-1:0];
            got.val = m_axis_tdata[OPOW_W +: ACC_W];
            got.lst = m_axis_tlast;
            sb.match_coef(got);
        end
        if (!stalls_on) begin
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < IDLE_START_PCT) begin
            sink_hold     <= $urandom_range(5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] pwr,
                             input logic [COEF_W-1:0] val, input logic lst);
        int gap;
        if (gaps_on && $urandom_range(99) < IDLE_START_PCT) begin
            gap = 1 + $urandom_range(5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(S_TDATA_W - IDX_W - COEF_W){1'b0}}, val, pwr};
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_item(act, pwr, val, lst);
        if (act <= ACT_MUL && !(act <= ACT_LOAD_B && pwr > MAX_DEGREE))
            items_taken++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    task automatic load_poly(input logic [ACT_W-1:0] act, input int deg);
        for (int p = 0; p < deg; p++)
            if ($urandom_range(9) != 0) send_item(act, IDX_W'(p), pick_coef(), 1'b0);
        send_item(act, IDX_W'(deg), pick_coef(), 1'b1);
    endtask

    initial begin
        int next_drain;
        int deg;
        int choice;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(ACT_ADD, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_MUL, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_LOAD_A, 4'd10, 16'h8000, 1'b1);
        send_item(ACT_LOAD_A, 4'd0, 16'h7fff, 1'b0);
        send_item(ACT_LOAD_B, 4'd10, 16'h8000, 1'b1);
        send_item(ACT_LOAD_B, 4'd0, 16'hffff, 1'b0);
        send_item(ACT_MUL, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_SUB, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_ADD, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_LOAD_A, 4'd11, 16'h1111, 1'b1);
        send_item(ACT_LOAD_A, 4'd15, 16'h7fff, 1'b1);
        send_item(ACT_LOAD_B, 4'd1, 16'h1234, 1'b1);
        send_item(ACT_LOAD_B, 4'd5, 16'h5a5a, 1'b0);
        send_item(ACT_ADD, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_MUL, 4'd0, 16'h0000, 1'b0);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            send_item(ACT_W'(a), 4'd0, 16'hffff, 1'b1);
        send_item(ACT_LOAD_A, 4'd0, 16'h8000, 1'b1);
        send_item(ACT_SUB, 4'd0, 16'h0000, 1'b0);
        send_item(ACT_MUL, 4'd0, 16'h0000, 1'b0);
        wait_drained();

        next_drain = items_taken + DRAIN_EVERY;
        while (items_taken < ITEM_TARGET) begin
            gaps_on   = !(items_taken >= 120 && items_taken < 200);
            stalls_on = gaps_on;
            if (items_taken >= next_drain) begin
                wait_drained();
                next_drain += DRAIN_EVERY;
            end
            choice = $urandom_range(99);
            if (choice < 65) begin
                deg = ($urandom_range(4) == 0) ? $urandom_range(MAX_DEGREE) : $urandom_range(3);
                load_poly($urandom_range(1) ? ACT_LOAD_B : ACT_LOAD_A, deg);
                if ($urandom_range(1)) begin
                    deg = ($urandom_range(4) == 0) ? $urandom_range(MAX_DEGREE)
                                                   : $urandom_range(3);
                    load_poly($urandom_range(1) ? ACT_LOAD_B : ACT_LOAD_A, deg);
                end
                send_item(calc_ops[$urandom_range(2)], IDX_W'($urandom),
                          COEF_W'($urandom), 1'($urandom));
                if ($urandom_range(2) == 0)
                    send_item(calc_ops[$urandom_range(2)], IDX_W'($urandom),
                              COEF_W'($urandom), 1'($urandom));
            end else if (choice < 82) begin
                send_item(calc_ops[$urandom_range(2)], IDX_W'($urandom),
                          COEF_W'($urandom), 1'($urandom));
            end else begin
                send_item(ACT_W'($urandom_range(ACT_SPARE_LAST)), IDX_W'($urandom_range(15)),
                          COEF_W'($urandom), 1'($urandom));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
